[sv/smsort_pkg.sv]
// Package for the stable merge sorter: defaults, field widths and sequencer states.
package smsort_pkg;

   // Default set capacity and element width
   localparam int DEPTH_DEF      = 64;
   localparam int VALUE_BITS_DEF = 16;

   // Width of the value fields on the ports
   localparam int FIELD_BITS = 16;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SETUP,
      ST_RUN_START,
      ST_MERGE,
      ST_EMIT
   } state_type;

endpackage

[sv/smsort_ram.sv]
// Generic RAM: one write port, two read ports, registered read data.
module smsort_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd0_addr,
   input  logic [AW-1:0]    rd1_addr,
   output logic [WIDTH-1:0] rd0_data,
   output logic [WIDTH-1:0] rd1_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd0_ff;
   logic [WIDTH-1:0] rd1_ff;

   // Write port and registered reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd0_ff <= mem_ff[rd0_addr];
      rd1_ff <= mem_ff[rd1_addr];
   end

   assign rd0_data = rd0_ff;
   assign rd1_data = rd1_ff;

endmodule

[sv/stable_merge_sorter_top.sv]
// Top level of the stable merge sorter: load, bottom-up merge passes, emit.
// Load: one transfer per cycle; busy stays low until the set closes (last, or DEPTH items).
// Sort: ceil(log2 n) passes (setup, run-start, merge states) on one compare/merge step.
// Emit: n results on consecutive cycles, after setup, emit state and output register.
// Results are strobed.
// Synchronous active-high reset clears the sequencer and count; RAM contents are undefined.
module stable_merge_sorter_top #(
   parameter int DEPTH      = smsort_pkg::DEPTH_DEF,
   parameter int VALUE_BITS = smsort_pkg::VALUE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [smsort_pkg::FIELD_BITS-1:0] req_value,
   input  logic                              req_last,
   output logic                              rsp_valid,
   output logic [smsort_pkg::FIELD_BITS-1:0] rsp_sorted_value,
   output logic                              rsp_final_res
);

   import smsort_pkg::*;

   localparam int EB = (VALUE_BITS < FIELD_BITS) ? VALUE_BITS : FIELD_BITS;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 2;

   state_type state_ff, state_in;

   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] n_ff, n_in;
   logic [SW-1:0] width_ff, width_in;
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] mid_ff, mid_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic [CW-1:0] a_ff, a_in;
   logic [CW-1:0] b_ff, b_in;
   logic [CW-1:0] k_ff, k_in;
   logic [CW-1:0] e_ff, e_in;
   logic          par_ff, par_in;
   logic          out_v_ff, out_v_in;
   logic          out_fin_ff, out_fin_in;

   logic          load_xfer;
   logic          set_close;
   logic [SW-1:0] lo_w_sum;
   logic [SW-1:0] lo_2w_sum;
   logic [CW-1:0] mid_calc;
   logic [CW-1:0] hi_calc;
   logic          run_last;
   logic          pass_last;
   logic          emit_last;
   logic          take_a;
   logic [EB-1:0] src_a;
   logic [EB-1:0] src_b;
   logic [EB-1:0] merged;

   logic [AW-1:0] rd0_addr;
   logic [AW-1:0] rd1_addr;
   logic          ram0_we;
   logic          ram1_we;
   logic [AW-1:0] wr_addr;
   logic [EB-1:0] ram0_wdata;
   logic [EB-1:0] r0_d0, r0_d1, r1_d0, r1_d1;

   // Two buffers: sorted runs ping-pong between them pass by pass
   smsort_ram #(.WIDTH(EB), .DEPTH(DEPTH)) u_ram0 (
      .clock    (clock),
      .wr_en    (ram0_we),
      .wr_addr  (wr_addr),
      .wr_data  (ram0_wdata),
      .rd0_addr (rd0_addr),
      .rd1_addr (rd1_addr),
      .rd0_data (r0_d0),
      .rd1_data (r0_d1)
   );

   smsort_ram #(.WIDTH(EB), .DEPTH(DEPTH)) u_ram1 (
      .clock    (clock),
      .wr_en    (ram1_we),
      .wr_addr  (wr_addr),
      .wr_data  (merged),
      .rd0_addr (rd0_addr),
      .rd1_addr (rd1_addr),
      .rd0_data (r1_d0),
      .rd1_data (r1_d1)
   );

   // Merge step datapath: the shared compare and pointer arithmetic
   always_comb begin
      load_xfer = start && (state_ff == ST_LOAD);
      set_close = req_last || (cnt_ff == CW'(DEPTH - 1));
      src_a     = par_ff ? r1_d0 : r0_d0;
      src_b     = par_ff ? r1_d1 : r0_d1;
      lo_w_sum  = SW'(lo_ff) + width_ff;
      lo_2w_sum = SW'(lo_ff) + (width_ff << 1);
      mid_calc  = (lo_w_sum >= SW'(n_ff)) ? n_ff : CW'(lo_w_sum);
      hi_calc   = (lo_2w_sum >= SW'(n_ff)) ? n_ff : CW'(lo_2w_sum);
      take_a    = (a_ff < mid_ff) && ((b_ff >= hi_ff) || (src_a <= src_b));
      merged    = take_a ? src_a : src_b;
      run_last  = (SW'(k_ff) + SW'(1)) == SW'(hi_ff);
      pass_last = lo_2w_sum >= SW'(n_ff);
      emit_last = (SW'(e_ff) + SW'(1)) == SW'(n_ff);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (load_xfer && set_close) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            state_in = (width_ff >= SW'(n_ff)) ? ST_EMIT : ST_RUN_START;
         end
         ST_RUN_START: begin
            state_in = ST_MERGE;
         end
         ST_MERGE: begin
            if (run_last) begin
               state_in = pass_last ? ST_SETUP : ST_RUN_START;
            end
         end
         ST_EMIT: begin
            if (emit_last) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // Sequencer outputs and register next values
   always_comb begin
      busy       = (state_ff != ST_LOAD);
      cnt_in     = cnt_ff;
      n_in       = n_ff;
      width_in   = width_ff;
      lo_in      = lo_ff;
      mid_in     = mid_ff;
      hi_in      = hi_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      k_in       = k_ff;
      e_in       = e_ff;
      par_in     = par_ff;
      out_v_in   = 1'b0;
      out_fin_in = 1'b0;
      rd0_addr   = a_ff[AW-1:0];
      rd1_addr   = b_ff[AW-1:0];
      ram0_we    = 1'b0;
      ram1_we    = 1'b0;
      wr_addr    = k_ff[AW-1:0];
      ram0_wdata = merged;
      case (state_ff)
         ST_LOAD: begin
            wr_addr    = cnt_ff[AW-1:0];
            ram0_wdata = req_value[EB-1:0];
            if (load_xfer) begin
               ram0_we = 1'b1;
               if (set_close) begin
                  n_in     = cnt_ff + CW'(1);
                  cnt_in   = '0;
                  width_in = SW'(1);
                  par_in   = 1'b0;
                  e_in     = '0;
               end else begin
                  cnt_in = cnt_ff + CW'(1);
               end
            end
         end
         ST_SETUP: begin
            lo_in = '0;
         end
         ST_RUN_START: begin
            // open a run pair and prefetch both heads
            mid_in   = mid_calc;
            hi_in    = hi_calc;
            a_in     = lo_ff;
            b_in     = mid_calc;
            k_in     = lo_ff;
            rd0_addr = lo_ff[AW-1:0];
            rd1_addr = mid_calc[AW-1:0];
         end
         ST_MERGE: begin
            // write the smaller head, fetch its successor
            ram0_we = par_ff;
            ram1_we = !par_ff;
            k_in    = k_ff + CW'(1);
            if (take_a) begin
               a_in     = a_ff + CW'(1);
               rd0_addr = a_in[AW-1:0];
            end else begin
               b_in     = b_ff + CW'(1);
               rd1_addr = b_in[AW-1:0];
            end
            if (run_last) begin
               lo_in = CW'(lo_2w_sum);
               if (pass_last) begin
                  width_in = width_ff << 1;
                  par_in   = !par_ff;
               end
            end
         end
         ST_EMIT: begin
            rd0_addr   = e_ff[AW-1:0];
            e_in       = e_ff + CW'(1);
            out_v_in   = 1'b1;
            out_fin_in = emit_last;
         end
         default: begin
         end
      endcase
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         cnt_ff     <= '0;
         out_v_ff   <= 1'b0;
         out_fin_ff <= 1'b0;
         par_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         out_v_ff   <= out_v_in;
         out_fin_ff <= out_fin_in;
         par_ff     <= par_in;
      end
      n_ff     <= n_in;
      width_ff <= width_in;
      lo_ff    <= lo_in;
      mid_ff   <= mid_in;
      hi_ff    <= hi_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      k_ff     <= k_in;
      e_ff     <= e_in;
   end

   // Result transfer straight from the buffer's read register
   assign rsp_valid        = out_v_ff;
   assign rsp_final_res    = out_fin_ff;
   assign rsp_sorted_value = FIELD_BITS'(src_a);

`ifndef SYNTH
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) == ST_EMIT)
      else $error("result strobe without emit cycle");

   a_final_needs_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_final_res |-> rsp_valid)
      else $error("final mark without result");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff < CW'(DEPTH))
      else $error("element count past capacity");

   a_merge_in_run: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MERGE |-> (k_ff < hi_ff) && (SW'(a_ff) + SW'(b_ff) ==
         SW'(k_ff) + SW'(mid_ff)))
      else $error("merge pointers out of step");

   a_final_ends_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_final_res |-> state_ff == ST_LOAD)
      else $error("final result while still sorting");
`endif

endmodule

[bench/stable_merge_sorter_top_tb.sv]
// Testbench for the stable merge sorter: load sets, predict the sorted order, check every result.
module stable_merge_sorter_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import smsort_pkg::*;

   localparam int SET_DEPTH   = DEPTH_DEF;
   localparam int CYCLE_LIMIT = 400000;
   localparam int TAIL_CYCLES = 1000;
   localparam int PHASE_ITEMS = 140;
   localparam int MAX_REPORTS = 10;

   typedef logic [FIELD_BITS-1:0] elem_q_type[$];

   typedef struct {
      logic [FIELD_BITS-1:0] value;
      logic                  last;
   } load_item_type;

   typedef struct {
      logic [FIELD_BITS-1:0] sorted_value;
      logic                  final_res;
   } sorted_elem_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [FIELD_BITS-1:0] req_value = '0;
   logic                  req_last = 1'b0;
   logic                  rsp_valid;
   logic [FIELD_BITS-1:0] rsp_sorted_value;
   logic                  rsp_final_res;

   load_item_type   pending_loads[$];
   sorted_elem_type sorted_expect[$];
   elem_q_type      open_set;

   int send_idle_pct = 27;
   int cycle_count   = 0;
   int fail_count    = 0;
   int loads_done    = 0;
   int sets_closed   = 0;
   int results_seen  = 0;
   int largest_set   = 0;
   int items_queued  = 0;

   stable_merge_sorter_top dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_value        (req_value),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_final_res    (rsp_final_res)
   );

   always #5 clock = ~clock;

   // Stable ascending sort; ties keep their arrival order
   function automatic elem_q_type sort_set(elem_q_type set_in);
      elem_q_type            a;
      logic [FIELD_BITS-1:0] key;
      int                    j;
      a = set_in;
      for (int i = 1; i < a.size(); i++) begin
         key = a[i];
         j = i - 1;
         while (j >= 0 && a[j] > key) begin
            a[j + 1] = a[j];
            j--;
         end
         a[j + 1] = key;
      end
      return a;
   endfunction

   // Predictor: store one element; a last mark or a full set emits the sorted set
   task automatic load_element(logic [FIELD_BITS-1:0] value, logic last);
      elem_q_type      sorted;
      sorted_elem_type r;
      open_set.insert(open_set.size(), value);
      loads_done++;
      if (last || open_set.size() == SET_DEPTH) begin
         sorted = sort_set(open_set);
         for (int i = 0; i < sorted.size(); i++) begin
            r.sorted_value = sorted[i];
            r.final_res    = (i == sorted.size() - 1);
            sorted_expect.insert(sorted_expect.size(), r);
         end
         if (open_set.size() > largest_set) largest_set = open_set.size();
         sets_closed++;
         open_set.delete();
      end
   endtask

   task automatic note_failure(string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS) $display("ERROR at cycle %0d: %s", cycle_count, msg);
   endtask

   // Cycle counter and timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results still expected",
                  cycle_count, sorted_expect.size());
         $display("stable_merge_sorter_top test failed");
         $finish;
      end
   end

   // Driver: record the transfer at this edge, then offer the next item or idle
   always @(posedge clock) begin
      load_item_type item;
      if (reset) begin
         start    <= 1'b0;
         req_value <= '0;
         req_last <= 1'b0;
      end else begin
         if (start && !busy) load_element(req_value, req_last);
         if (!start || !busy) begin
            if (pending_loads.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               item = pending_loads.pop_front();
               start     <= 1'b1;
               req_value <= item.value;
               req_last  <= item.last;
            end else begin
               start     <= 1'b0;
               req_value <= FIELD_BITS'($urandom);
               req_last  <= 1'($urandom);
            end
         end
      end
   end

   // Monitor: each strobed result against the oldest expectation
   always @(posedge clock) begin
      sorted_elem_type e;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (sorted_expect.size() == 0) begin
            note_failure($sformatf("unexpected result value=%h final=%b",
                                   rsp_sorted_value, rsp_final_res));
         end else begin
            e = sorted_expect.pop_front();
            if (rsp_sorted_value !== e.sorted_value || rsp_final_res !== e.final_res)
               note_failure($sformatf("expected value=%h final=%b, got value=%h final=%b",
                                      e.sorted_value, e.final_res,
                                      rsp_sorted_value, rsp_final_res));
         end
      end
   end

   task automatic push_item(logic [FIELD_BITS-1:0] value, logic last);
      load_item_type item;
      item.value = value;
      item.last  = last;
      pending_loads.insert(pending_loads.size(), item);
      items_queued++;
   endtask

   // Element value by flavor: full range, tie-heavy, extremes, or a narrow band
   function automatic logic [FIELD_BITS-1:0] pick_value(int flavor);
      case (flavor)
         0: begin
            return FIELD_BITS'($urandom_range(3));
         end
         1: begin
            return ($urandom_range(1) != 0) ? '1 : '0;
         end
         2: begin
            return FIELD_BITS'(16'hFFF0 + $urandom_range(15));
         end
         default: begin
            return FIELD_BITS'($urandom);
         end
      endcase
   endfunction

   // One set of n elements; a full set may close with or without the last mark
   task automatic queue_set(int n, bit mark_full);
      int flavor;
      flavor = $urandom_range(5);
      for (int i = 0; i < n; i++)
         push_item(pick_value(flavor), (i == n - 1) && (n < SET_DEPTH || mark_full));
   endtask

   // Random sets, mostly small, until the phase has enough items
   task automatic queue_random_sets(int count);
      int goal, r, n;
      goal = items_queued + count;
      while (items_queued < goal) begin
         r = $urandom_range(99);
         if (r < 70) n = $urandom_range(8, 1);
         else if (r < 90) n = $urandom_range(32, 9);
         else n = $urandom_range(SET_DEPTH, 33);
         queue_set(n, 1'($urandom_range(1)));
      end
   endtask

   task automatic drain();
      while (pending_loads.size() != 0 || start || sorted_expect.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: single elements at both extremes, reversed pair, ties, bit patterns, sorted run
      send_idle_pct = 27;
      push_item(16'h0000, 1'b1);
      push_item(16'hFFFF, 1'b1);
      push_item(16'hFFFF, 1'b0);
      push_item(16'h0000, 1'b1);
      push_item(16'h0005, 1'b0);
      push_item(16'h0005, 1'b0);
      push_item(16'h0003, 1'b0);
      push_item(16'h0005, 1'b0);
      push_item(16'hFFFF, 1'b0);
      push_item(16'h0005, 1'b1);
      push_item(16'hAAAA, 1'b0);
      push_item(16'h5555, 1'b0);
      push_item(16'h8000, 1'b0);
      push_item(16'h0001, 1'b1);
      push_item(16'h0001, 1'b0);
      push_item(16'h0002, 1'b0);
      push_item(16'h0003, 1'b1);
      queue_random_sets(PHASE_ITEMS - items_queued);
      drain();

      // Sender mostly idle
      send_idle_pct = 69;
      queue_random_sets(PHASE_ITEMS);
      drain();

      // Back to back, including full sets closed with and without the last mark
      send_idle_pct = 0;
      queue_set(SET_DEPTH, 1'b0);
      queue_set(SET_DEPTH, 1'b1);
      queue_random_sets(PHASE_ITEMS - 2 * SET_DEPTH);
      drain();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (sorted_expect.size() != 0)
         note_failure($sformatf("%0d expected results never arrived", sorted_expect.size()));

      $display("Loaded %0d elements in %0d sets (largest %0d), checked %0d results",
               loads_done, sets_closed, largest_set, results_seen);
      $display("Sender idle rates 27, 69 and 0 percent; %0d failures", fail_count);
      if (fail_count == 0) begin
         $display("stable_merge_sorter_top test passed");
      end else begin
         $display("stable_merge_sorter_top test failed");
      end
      $finish;
   end

endmodule
